// ===== src/eln_pkg.sv =====
package eln_pkg;

    localparam int MaxEventsDefault  = 64;
    localparam int LevelWidthDefault = 16;
    localparam int CfgWidth          = 16;
    localparam int CfgIdxWidth       = 2;
    localparam int OutWidth          = 16;
    localparam int SumWidth          = 22;

    localparam logic [CfgIdxWidth-1:0] CfgModelMean  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgModelStdv  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgFixedScale = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CfgFixedShift = 2'd3;

    typedef struct packed {
        logic load;
        logic clear;
        logic acc_start;
        logic acc_en;
        logic var_start;
        logic sqrt_start;
        logic div_start;
        logic mdiv_start;
        logic shift_calc;
        logic emit_rd;
        logic use_fixed;
    } t_cmd;

    typedef struct packed {
        logic store_full;
        logic d_zero;
        logic sqrt_done;
        logic div_done;
        logic mdiv_done;
    } t_status;

endpackage

// ===== src/event_level_normalizer.sv =====
// Batch normalizer: levels are stored one per cycle until batch_end; then,
// unless fixed_scale is nonzero, a second pass sums squares, an iterative
// square root runs, then the scale divider (skipped on zero spread) and the
// mean divider plus shift; each level is then read, scaled, saturated and
// emitted, and held while the output is stalled. With a fixed scale the
// batch goes straight to emission. Input is stalled from batch_end until
// the last result of the batch has been taken.
module event_level_normalizer
    import eln_pkg::*;
#(
    parameter int MAX_EVENTS  = MaxEventsDefault,
    parameter int LEVEL_WIDTH = LevelWidthDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [15:0]             i_level,
    input  logic                    i_batch_end,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgWidth-1:0]     i_cfg_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [15:0]      o_scaled_level,
    output logic                    o_final_res,
    output logic                    o_zero_spread,
    output logic                    o_overflowed
);

    logic [CfgWidth-1:0]        r_model_mean;
    logic [CfgWidth-1:0]        r_model_stdv;
    logic [CfgWidth-1:0]        r_fixed_scale;
    logic signed [CfgWidth-1:0] r_fixed_shift;
    t_cmd                       w_cmd;
    t_status                    w_status;
    logic [$clog2(MAX_EVENTS):0]   w_fill;
    logic [$clog2(MAX_EVENTS)-1:0] w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_mean  <= '0;
            r_model_stdv  <= '0;
            r_fixed_scale <= '0;
            r_fixed_shift <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgModelMean:  r_model_mean  <= i_cfg_data;
                CfgModelStdv:  r_model_stdv  <= i_cfg_data;
                CfgFixedScale: r_fixed_scale <= i_cfg_data;
                CfgFixedShift: r_fixed_shift <= i_cfg_data;
                default: ;
            endcase
        end
    end

    eln_ctrl #(.MaxEvents(MAX_EVENTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_batch_end(i_batch_end),
        .i_fixed    (r_fixed_scale != '0),
        .i_out_stall(i_stall),
        .i_status   (w_status),
        .i_fill     (w_fill),
        .o_stall    (o_stall),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx),
        .o_valid    (o_valid),
        .o_final    (o_final_res),
        .o_zero     (o_zero_spread),
        .o_over     (o_overflowed)
    );

    eln_datapath #(.MaxEvents(MAX_EVENTS), .LevelWidth(LEVEL_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_level      (i_level),
        .i_idx        (w_idx),
        .i_model_mean (r_model_mean),
        .i_model_stdv (r_model_stdv),
        .i_fixed_scale(r_fixed_scale),
        .i_fixed_shift(r_fixed_shift),
        .o_status     (w_status),
        .o_fill       (w_fill),
        .o_scaled     (o_scaled_level)
    );

endmodule

// ===== src/eln_ram.sv =====
module eln_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/eln_div.sv =====
// Restoring divider, one quotient bit per cycle.
module eln_div #(
    parameter int NumWidth = 64,
    parameter int DenWidth = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NumWidth-1:0] i_num,
    input  logic [DenWidth-1:0] i_den,
    output logic [NumWidth-1:0] o_quot,
    output logic                o_done
);

    localparam int CntWidth = $clog2(NumWidth + 1);

    logic [NumWidth-1:0] r_quot;
    logic [DenWidth:0]   r_rem;
    logic [DenWidth-1:0] r_den;
    logic [CntWidth-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DenWidth:0]   w_trial;

    assign w_trial = {r_rem[DenWidth-1:0], r_quot[NumWidth-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CntWidth'(NumWidth);
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem  <= w_trial - {1'b0, r_den};
                    r_quot <= {r_quot[NumWidth-2:0], 1'b1};
                end else begin
                    r_rem  <= w_trial;
                    r_quot <= {r_quot[NumWidth-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntWidth'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// ===== src/eln_sqrt.sv =====
// Bit-pair integer square root, one result bit per cycle.
module eln_sqrt #(
    parameter int InWidth = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [InWidth-1:0]   i_val,
    output logic [InWidth/2-1:0] o_root,
    output logic                 o_done
);

    localparam int RootWidth = InWidth / 2;
    localparam int CntWidth  = $clog2(RootWidth + 1);

    logic [InWidth-1:0]   r_val;
    logic [RootWidth+1:0] r_rem;
    logic [RootWidth-1:0] r_root;
    logic [CntWidth-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [RootWidth+1:0] w_rem;
    logic [RootWidth+1:0] w_try;

    assign w_rem = {r_rem[RootWidth-1:0], r_val[InWidth-1:InWidth-2]};
    assign w_try = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CntWidth'(RootWidth);
            end else if (r_busy) begin
                r_val <= {r_val[InWidth-3:0], 2'b00};
                if (w_rem >= w_try) begin
                    r_rem  <= w_rem - w_try;
                    r_root <= {r_root[RootWidth-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem;
                    r_root <= {r_root[RootWidth-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntWidth'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ===== src/eln_datapath.sv =====
module eln_datapath
    import eln_pkg::*;
#(
    parameter int MaxEvents  = MaxEventsDefault,
    parameter int LevelWidth = LevelWidthDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [15:0]                 i_level,
    input  logic [$clog2(MaxEvents)-1:0] i_idx,
    input  logic [CfgWidth-1:0]         i_model_mean,
    input  logic [CfgWidth-1:0]         i_model_stdv,
    input  logic [CfgWidth-1:0]         i_fixed_scale,
    input  logic signed [CfgWidth-1:0]  i_fixed_shift,
    output t_status                     o_status,
    output logic [$clog2(MaxEvents):0]  o_fill,
    output logic signed [OutWidth-1:0]  o_scaled
);

    localparam int AddrWidth = $clog2(MaxEvents);
    localparam int LvlBits   = (LevelWidth < 16) ? LevelWidth : 16;
    localparam int S2Width   = 32 + AddrWidth + 1;
    localparam int SqWidth   = 64;
    localparam int RootWidth = SqWidth / 2;
    localparam int DivNum    = 48;

    logic [AddrWidth:0]        r_fill;
    logic [SumWidth-1:0]       r_sum;
    logic [S2Width-1:0]        r_s2;
    logic [31:0]               r_sq;
    logic                      r_rd_v;
    logic                      r_sq_v;
    logic [43:0]               r_d;
    logic [15:0]               r_scale;
    logic signed [35:0]        r_shift;
    logic signed [35:0]        r_prod;
    logic signed [OutWidth-1:0] r_out;
    logic [15:0]               w_rd;
    logic [15:0]               w_lvl;
    logic [43:0]               r_ns2;
    logic [43:0]               r_s1sq;
    logic [RootWidth-1:0]      w_root;
    logic                      w_sqrt_done;
    logic [DivNum-1:0]         w_q;
    logic                      w_div_done;
    logic [DivNum-1:0]         w_mq;
    logic                      w_mdiv_done;
    logic [DivNum-1:0]         w_num;
    logic [37:0]               r_ms1;
    logic signed [37:0]        w_sum;
    logic signed [25:0]        w_y;
    logic                      r_sqrt_go;

    assign w_lvl = 16'(i_level[LvlBits-1:0]);

    eln_ram #(.Width(16), .Depth(MaxEvents)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && !o_status.store_full),
        .i_waddr(r_fill[AddrWidth-1:0]),
        .i_wdata(w_lvl),
        .i_raddr(i_idx),
        .o_rdata(w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
            r_rd_v <= 1'b0;
            r_sq_v <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_fill <= '0;
                r_sum  <= '0;
            end else if (i_cmd.load && !o_status.store_full) begin
                r_fill <= r_fill + 1'b1;
                r_sum  <= r_sum + SumWidth'(w_lvl);
            end
            // read data and square are each registered; r_rd_v and r_sq_v track them
            r_rd_v <= i_cmd.acc_en;
            r_sq_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= 32'(w_rd) * 32'(w_rd);
        if (i_cmd.acc_start) begin
            r_s2 <= '0;
        end else if (r_sq_v) begin
            r_s2 <= r_s2 + S2Width'(r_sq);
        end
        if (i_cmd.var_start) begin
            r_ns2  <= 44'(r_s2) * 44'(r_fill);
            r_s1sq <= 44'(r_sum) * 44'(r_sum);
        end
        if (i_cmd.sqrt_start) begin
            r_d <= r_ns2 - r_s1sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqrt_go <= 1'b0;
        end else begin
            r_sqrt_go <= i_cmd.sqrt_start;
        end
    end

    eln_sqrt #(.InWidth(SqWidth)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_sqrt_go),
        .i_val  ({r_d[43:0], 20'd0}),
        .o_root (w_root),
        .o_done (w_sqrt_done)
    );

    assign w_num = DivNum'({i_model_stdv, 22'd0}) * DivNum'(r_fill);

    eln_div #(.NumWidth(DivNum), .DenWidth(RootWidth)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_root),
        .o_quot (w_q),
        .o_done (w_div_done)
    );

    eln_div #(.NumWidth(DivNum), .DenWidth(AddrWidth + 1)) u_mdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.mdiv_start),
        .i_num  (DivNum'(r_ms1)),
        .i_den  (r_fill),
        .o_quot (w_mq),
        .o_done (w_mdiv_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.use_fixed) begin
            r_scale <= i_fixed_scale;
            r_shift <= 36'(i_fixed_shift) <<< 12;
        end else begin
            if (i_cmd.sqrt_start) begin
                r_scale <= 16'hFFFF;
            end
            if (w_div_done) begin
                r_scale <= (w_q > DivNum'(16'hFFFF)) ? 16'hFFFF : w_q[15:0];
            end
            if (i_cmd.shift_calc) begin
                r_shift <= $signed({8'd0, i_model_mean, 12'd0})
                           - $signed({1'b0, w_mq[34:0]});
            end
        end
        r_ms1 <= 38'(r_scale) * 38'(r_sum);
        r_prod <= $signed({20'd0, r_scale}) * $signed({20'd0, w_rd});
    end

    assign w_sum = 38'(r_prod) + 38'(r_shift) + 38'sd2048;
    assign w_y   = 26'(w_sum >>> 12);

    always_ff @(posedge i_clk) begin
        if (w_y > 26'sd32767) begin
            r_out <= 16'sh7FFF;
        end else if (w_y < -26'sd32768) begin
            r_out <= 16'sh8000;
        end else begin
            r_out <= w_y[15:0];
        end
    end

    assign o_status.store_full = (r_fill == (AddrWidth + 1)'(MaxEvents));
    assign o_status.d_zero     = (r_d == '0);
    assign o_status.sqrt_done  = w_sqrt_done;
    assign o_status.div_done   = w_div_done;
    assign o_status.mdiv_done  = w_mdiv_done;
    assign o_fill   = r_fill;
    assign o_scaled = r_out;

endmodule

// ===== src/eln_ctrl.sv =====
module eln_ctrl
    import eln_pkg::*;
#(
    parameter int MaxEvents = MaxEventsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_batch_end,
    input  logic                         i_fixed,
    input  logic                         i_out_stall,
    input  t_status                      i_status,
    input  logic [$clog2(MaxEvents):0]   i_fill,
    output logic                         o_stall,
    output t_cmd                         o_cmd,
    output logic [$clog2(MaxEvents)-1:0] o_idx,
    output logic                         o_valid,
    output logic                         o_final,
    output logic                         o_zero,
    output logic                         o_over
);

    localparam int AddrWidth = $clog2(MaxEvents);

    typedef enum logic [3:0] {
        S_LOAD, S_ACC, S_ACC_WAIT, S_VAR, S_SUB, S_SQRT, S_DIV, S_MS1, S_MDIV,
        S_SHIFT, S_EMIT_RD, S_EMIT_MUL, S_EMIT_SAT, S_EMIT_OUT
    } t_state;

    t_state             r_state;
    logic [AddrWidth:0] r_idx;
    logic [2:0]         r_wait;
    logic               r_drop;
    logic               r_zero;
    logic               r_valid;
    logic               r_final;
    logic               w_acc;

    assign w_acc = i_valid && (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_wait  <= '0;
            r_drop  <= 1'b0;
            r_zero  <= 1'b0;
            r_valid <= 1'b0;
            r_final <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (i_status.store_full) begin
                            r_drop <= 1'b1;
                        end
                        if (i_batch_end) begin
                            r_idx  <= '0;
                            r_zero <= 1'b0;
                            r_state <= i_fixed ? S_EMIT_RD : S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == i_fill) begin
                        r_wait  <= 3'd3;
                        r_state <= S_ACC_WAIT;
                    end
                end
                S_ACC_WAIT: begin
                    r_wait <= r_wait - 1'b1;
                    if (r_wait == 3'd0) begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: r_state <= S_SUB;
                S_SUB: r_state <= S_SQRT;
                S_SQRT: begin
                    if (i_status.d_zero) begin
                        r_zero  <= 1'b1;
                        r_state <= S_MS1;
                    end else if (i_status.sqrt_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= S_MS1;
                    end
                end
                S_MS1: begin
                    r_wait  <= 3'd1;
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    r_wait <= 3'd0;
                    if (i_status.mdiv_done) begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_idx   <= '0;
                    r_state <= S_EMIT_RD;
                end
                S_EMIT_RD:  r_state <= S_EMIT_MUL;
                S_EMIT_MUL: r_state <= S_EMIT_SAT;
                S_EMIT_SAT: begin
                    r_valid <= 1'b1;
                    r_final <= (r_idx + 1'b1 == i_fill);
                    r_state <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (!i_out_stall) begin
                        r_valid <= 1'b0;
                        if (r_final) begin
                            r_drop  <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = w_acc;
        o_cmd.clear      = (r_state == S_EMIT_OUT) && !i_out_stall && r_final;
        o_cmd.acc_start  = w_acc && i_batch_end;
        o_cmd.acc_en     = (r_state == S_ACC);
        o_cmd.var_start  = (r_state == S_VAR);
        o_cmd.sqrt_start = (r_state == S_SUB);
        o_cmd.div_start  = (r_state == S_SQRT) && !i_status.d_zero && i_status.sqrt_done;
        o_cmd.mdiv_start = (r_state == S_MDIV) && (r_wait == 3'd1);
        o_cmd.shift_calc = (r_state == S_SHIFT);
        o_cmd.emit_rd    = (r_state == S_EMIT_RD);
        o_cmd.use_fixed  = w_acc && i_batch_end && i_fixed;
    end

    assign o_stall = (r_state != S_LOAD);
    assign o_idx   = r_idx[AddrWidth-1:0];
    assign o_valid = r_valid;
    assign o_final = r_final;
    assign o_zero  = r_zero;
    assign o_over  = r_drop;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !o_cmd.load) else $error("load while busy");
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_EMIT_OUT)) else $error("valid outside emit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_out_stall) |=> o_valid) else $error("result dropped");
`endif

endmodule

// ===== verif/event_level_normalizer_test.sv =====
`timescale 1ns / 1ps

module event_level_normalizer_test;
    import eln_pkg::*;

    localparam int Depth = 64;

    typedef struct {
        logic signed [15:0] scaled_level;
        logic               final_res;
        logic               zero_spread;
        logic               overflowed;
    } t_norm_res;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [15:0]            i_level;
    logic                   i_batch_end;
    logic                   i_cfg_we;
    logic [CfgIdxWidth-1:0] i_cfg_idx;
    logic [CfgWidth-1:0]    i_cfg_data;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [15:0]     o_scaled_level;
    logic                   o_final_res;
    logic                   o_zero_spread;
    logic                   o_overflowed;

    event_level_normalizer i_dut (.*);

    logic [15:0] lvl_mem [Depth];
    int unsigned lvl_fill;
    logic [21:0] lvl_sum;
    bit          lvl_dropped;
    logic [15:0] reg_mean, reg_stdv, reg_fscale;
    logic signed [15:0] reg_fshift;

    t_norm_res expected_levels[$];
    int unsigned error_count;
    bit hold_off;
    bit dense;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic predict_batch(logic [15:0] x, bit last);
        logic [63:0] n, s1, s2, d, sd, scale;
        longint shift, v, y;
        bit zero;
        t_norm_res r;
        zero = 0;
        if (lvl_fill < Depth) begin
            lvl_mem[lvl_fill] = x;
            lvl_fill++;
            lvl_sum = lvl_sum + x;
        end else begin
            lvl_dropped = 1;
        end
        if (!last) return;
        n = lvl_fill;
        s1 = lvl_sum;
        if (reg_fscale != 0) begin
            scale = reg_fscale;
            shift = longint'(reg_fshift) * 4096;
        end else begin
            s2 = 0;
            for (int i = 0; i < lvl_fill; i++) s2 += lvl_mem[i] * lvl_mem[i];
            d = n * s2 - s1 * s1;
            if (d == 0) begin
                scale = 65535;
                zero = 1;
            end else begin
                sd = isqrt(d << 20);
                scale = ((64'(reg_stdv) * n) << 22) / sd;
                if (scale > 65535) scale = 65535;
            end
            shift = longint'(reg_mean) * 4096 - longint'((scale * s1) / n);
        end
        for (int i = 0; i < lvl_fill; i++) begin
            v = longint'(scale * lvl_mem[i]) + shift + 2048;
            y = (v >= 0) ? v / 4096 : -((-v + 4095) / 4096);
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            r.scaled_level = y[15:0];
            r.final_res = (i + 1 == lvl_fill);
            r.zero_spread = zero;
            r.overflowed = lvl_dropped;
            expected_levels = {expected_levels, r};
        end
        lvl_fill = 0;
        lvl_sum = 0;
        lvl_dropped = 0;
    endtask

    task automatic report_mismatch(string what, int got, int exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected transaction", o_scaled_level, 0);
            end else begin
                t_norm_res e;
                e = expected_levels.pop_front();
                if (o_scaled_level !== e.scaled_level)
                    report_mismatch("scaled_level", o_scaled_level, e.scaled_level);
                if (o_final_res !== e.final_res)
                    report_mismatch("final_res", o_final_res, e.final_res);
                if (o_zero_spread !== e.zero_spread)
                    report_mismatch("zero_spread", o_zero_spread, e.zero_spread);
                if (o_overflowed !== e.overflowed)
                    report_mismatch("overflowed", o_overflowed, e.overflowed);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else if (dense) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0);
    end

    task automatic send_level(logic [15:0] x, bit last);
        i_valid <= 1'b1;
        i_level <= x;
        i_batch_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_batch(x, last);
        if (!dense && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgModelMean:  reg_mean = val;
            CfgModelStdv:  reg_stdv = val;
            CfgFixedScale: reg_fscale = val;
            CfgFixedShift: reg_fshift = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] m, logic [15:0] s, logic [15:0] fs,
                            logic [15:0] fh);
        write_reg(CfgModelMean, m);
        write_reg(CfgModelStdv, s);
        write_reg(CfgFixedScale, fs);
        write_reg(CfgFixedShift, fh);
    endtask

    task automatic send_batch(int len, int maxv);
        for (int i = 0; i < len; i++)
            send_level(16'($urandom_range(0, maxv)), i == len - 1);
    endtask

    task automatic test_directed();
        set_regs(16'd1600, 16'd200, 16'd0, 16'd0);
        send_level(16'h0000, 0);
        send_level(16'hFFFF, 0);
        send_level(16'h5555, 0);
        send_level(16'hAAAA, 1);
        send_level(16'd777, 1);
        send_level(16'd40, 0);
        send_level(16'd40, 0);
        send_level(16'd40, 1);
        drain();
        set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_level(16'd100, 0);
        send_level(16'd101, 1);
        drain();
        set_regs(16'd0, 16'd1, 16'hFFFF, 16'h7FFF);
        send_level(16'hFFFF, 0);
        send_level(16'h0000, 1);
        drain();
        set_regs(16'd0, 16'd0, 16'h0001, 16'h8000);
        send_level(16'hFFFF, 0);
        send_level(16'h0000, 1);
        drain();
    endtask

    task automatic test_overflow();
        set_regs(16'd1000, 16'd300, 16'd0, 16'd0);
        send_batch(Depth + 3, 65535);
        drain();
    endtask

    task automatic test_random();
        for (int b = 0; b < 24; b++) begin
            if (b % 6 == 0)
                set_regs(16'($urandom), 16'($urandom_range(0, 2000)),
                         ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd0,
                         16'($urandom));
            dense = (b % 5 == 4);
            send_batch($urandom_range(1, 30),
                       ($urandom_range(0, 1) != 0) ? 65535 : 4000);
            if (b % 6 == 5) drain();
        end
        dense = 0;
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                send_batch(20, 65535);
                send_batch(20, 65535);
            end
        join
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_level = '0;
        i_batch_end = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_stall = 1'b0;
        hold_off = 0;
        dense = 0;
        error_count = 0;
        lvl_fill = 0;
        lvl_sum = 0;
        lvl_dropped = 0;
        reg_mean = 0;
        reg_stdv = 0;
        reg_fscale = 0;
        reg_fshift = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
